// File: sv/lfu_pkg.sv
package lfu_pkg;

	localparam int MODE_W   = 2;
	localparam int HANDLE_W = 6;
	localparam int FCOUNT_W = 16;
	localparam int STATUS_W = 3;
	localparam int OCC_W    = 7;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 2'd0,
		MODE_TOUCH  = 2'd1,
		MODE_EVICT  = 2'd2
	} lfu_mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 3'd0,
		ST_FULL   = 3'd1,
		ST_EMPTY  = 3'd2,
		ST_ABSENT = 3'd3,
		ST_DUP    = 3'd4
	} lfu_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EV_ROOT,
		S_TS_WAIT,
		S_LD_CUR,
		S_UP_CHK,
		S_UP_CMP,
		S_DN_CHK,
		S_DN_L,
		S_DN_R,
		S_DN_CMP,
		S_PLACE,
		S_DONE
	} lfu_state_t;

endpackage

// File: sv/lfu_in_if.sv
interface lfu_in_if import lfu_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [HANDLE_W-1:0] handle;
	logic [FCOUNT_W-1:0] start_count;

	modport source (output valid, output mode, output handle, output start_count, input ready);
	modport sink (input valid, input mode, input handle, input start_count, output ready);
endinterface

// File: sv/lfu_out_if.sv
interface lfu_out_if import lfu_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] evicted_handle;
	logic [FCOUNT_W-1:0] evicted_count;
	logic [OCC_W-1:0]    occupancy;

	modport source (output valid, output status, output evicted_handle,
		output evicted_count, output occupancy, input ready);
	modport sink (input valid, input status, input evicted_handle,
		input evicted_count, input occupancy, output ready);
endinterface

// File: sv/lfu_min_heap_eviction_queue.sv
// LFU eviction queue kept as a binary min-heap of (handle, access count).
// Request channel req carries mode, handle and start_count; every accepted
// word yields exactly one word on the response channel rsp with status,
// evicted_handle, evicted_count and occupancy.
// Insert sifts the new entry up, touch bumps a count (saturating) and sifts
// it down, evict reports the root and sifts the last entry down from the top.
// One request is worked at a time; req.ready is high only while idle.
// A rejected or unused request goes straight to the response; an evict that
// empties the heap reports the root with no sift. Insert climbs level by
// level, and touch and evict descend level by level, until the entry is
// placed; req.ready returns as rsp.valid rises. The heap memory sets the
// pace: one registered read per cycle, so each level needs the parent or
// both children read in turn before the move is written back.
// The response sits in an output register; while rsp.ready is low the block
// may take the next request and finish its work, then waits with its
// result until the register frees.
// Reset (arst_n low) empties the heap: the present flags and the size clear
// at once, there is no memory clearing pass, and requests are taken in the
// first cycle after reset.
module lfu_min_heap_eviction_queue import lfu_pkg::*; #(
	parameter int HEAP_DEPTH  = 64,
	parameter int NUM_HANDLES = 64,
	parameter int COUNT_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	lfu_in_if.sink     req,
	lfu_out_if.source  rsp
);

	localparam int PRES_N = (NUM_HANDLES < 2**HANDLE_W) ? NUM_HANDLES : 2**HANDLE_W;
	localparam int HIX_W  = $clog2(PRES_N);
	localparam int SL_W   = $clog2(HEAP_DEPTH);
	localparam int SZ_W   = $clog2(HEAP_DEPTH + 1);
	localparam int CH_W   = SL_W + 2;

	typedef struct packed {
		logic [HIX_W-1:0]       h;
		logic [COUNT_WIDTH-1:0] c;
	} ent_t;

	lfu_state_t state_q, state_d;

	logic [SZ_W-1:0]   size_q;
	logic [PRES_N-1:0] present_q;
	logic [MODE_W-1:0] mode_q;
	logic [SL_W-1:0]   i_q;
	logic [SL_W-1:0]   ch_slot_q;
	ent_t              cur_q, ch_q, ev_q;
	lfu_status_t       status_q;

	logic                rsp_valid_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [HANDLE_W-1:0] rsp_ev_h_q;
	logic [FCOUNT_W-1:0] rsp_ev_c_q;
	logic [OCC_W-1:0]    rsp_occ_q;

	logic              acc, acc_go, rsp_load;
	lfu_status_t       acc_status;
	logic [HIX_W-1:0]  hidx;
	logic              h_ok, full;
	logic [CH_W-1:0]   lc, rc, size_x;
	logic              lc_in, rc_in;
	logic [SL_W-1:0]   parent;

	logic              h_we, s_we;
	logic [SL_W-1:0]   h_waddr, h_raddr, s_wdata;
	ent_t              h_wdata, hrd;
	logic [HIX_W-1:0]  s_waddr, s_raddr;
	logic [SL_W-1:0]   sl_rd;

	logic [COUNT_WIDTH-1:0] cmp_a, cmp_b;
	logic                   cmp_le;
	logic [COUNT_WIDTH-1:0] cnt_inc;

	lfu_ram #(.WIDTH(HIX_W + COUNT_WIDTH), .DEPTH(HEAP_DEPTH)) u_heap_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (hrd)
	);

	lfu_ram #(.WIDTH(SL_W), .DEPTH(PRES_N)) u_slot_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (sl_rd)
	);

	assign acc      = req.valid && req.ready;
	assign hidx     = req.handle[HIX_W-1:0];
	assign h_ok     = int'(req.handle) < NUM_HANDLES;
	assign full     = size_q >= SZ_W'(HEAP_DEPTH);
	assign lc       = {1'b0, i_q, 1'b1};
	assign rc       = lc + CH_W'(1);
	assign size_x   = CH_W'(size_q);
	assign lc_in    = lc < size_x;
	assign rc_in    = rc < size_x;
	assign parent   = (i_q - SL_W'(1)) >> 1;
	assign cmp_le   = cmp_a <= cmp_b;
	assign cnt_inc  = (hrd.c == '1) ? hrd.c : hrd.c + COUNT_WIDTH'(1);
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		acc_go     = 1'b0;
		acc_status = ST_OK;
		case (req.mode)
			MODE_INSERT: begin
				if (full) begin
					acc_status = ST_FULL;
				end else if (!h_ok) begin
					acc_status = ST_ABSENT;
				end else if (present_q[hidx]) begin
					acc_status = ST_DUP;
				end else begin
					acc_go = 1'b1;
				end
			end
			MODE_TOUCH: begin
				if (!h_ok || !present_q[hidx]) begin
					acc_status = ST_ABSENT;
				end else begin
					acc_go = 1'b1;
				end
			end
			MODE_EVICT: begin
				if (size_q == '0) begin
					acc_status = ST_EMPTY;
				end else begin
					acc_go = 1'b1;
				end
			end
			default: begin
				acc_go = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (!acc_go) begin
						state_d = S_DONE;
					end else if (req.mode == MODE_INSERT) begin
						state_d = S_UP_CHK;
					end else if (req.mode == MODE_TOUCH) begin
						state_d = S_TS_WAIT;
					end else begin
						state_d = S_EV_ROOT;
					end
				end
			end
			S_EV_ROOT: state_d = (size_q == '0) ? S_DONE : S_LD_CUR;
			S_TS_WAIT: state_d = S_LD_CUR;
			S_LD_CUR:  state_d = S_DN_CHK;
			S_UP_CHK:  state_d = (i_q == '0) ? S_PLACE : S_UP_CMP;
			S_UP_CMP:  state_d = cmp_le ? S_UP_CHK : S_PLACE;
			S_DN_CHK:  state_d = lc_in ? S_DN_L : S_PLACE;
			S_DN_L:    state_d = rc_in ? S_DN_R : S_DN_CMP;
			S_DN_R:    state_d = S_DN_CMP;
			S_DN_CMP:  state_d = cmp_le ? S_PLACE : S_DN_CHK;
			S_PLACE:   state_d = S_DONE;
			S_DONE: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == S_IDLE);
		h_we      = 1'b0;
		h_waddr   = i_q;
		h_wdata   = cur_q;
		h_raddr   = '0;
		s_we      = 1'b0;
		s_waddr   = cur_q.h;
		s_wdata   = i_q;
		s_raddr   = hidx;
		cmp_a     = cur_q.c;
		cmp_b     = ch_q.c;
		case (state_q)
			S_EV_ROOT: h_raddr = SL_W'(size_q);
			S_TS_WAIT: h_raddr = sl_rd;
			S_UP_CHK:  h_raddr = parent;
			S_UP_CMP: begin
				cmp_b   = hrd.c;
				h_we    = cmp_le;
				h_wdata = hrd;
				s_we    = cmp_le;
				s_waddr = hrd.h;
			end
			S_DN_CHK:  h_raddr = lc[SL_W-1:0];
			S_DN_L:    h_raddr = rc[SL_W-1:0];
			S_DN_R: begin
				cmp_a = hrd.c;
			end
			S_DN_CMP: begin
				h_we    = !cmp_le;
				h_wdata = ch_q;
				s_we    = !cmp_le;
				s_waddr = ch_q.h;
			end
			S_PLACE: begin
				h_we = 1'b1;
				s_we = 1'b1;
			end
			default: begin
				h_raddr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			size_q      <= '0;
			present_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc && acc_go && req.mode == MODE_INSERT) begin
				size_q          <= size_q + SZ_W'(1);
				present_q[hidx] <= 1'b1;
			end else if (acc && acc_go && req.mode == MODE_EVICT) begin
				size_q <= size_q - SZ_W'(1);
			end
			if (state_q == S_EV_ROOT) begin
				present_q[hrd.h] <= 1'b0;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					mode_q   <= req.mode;
					status_q <= acc_status;
					ev_q     <= '0;
					cur_q    <= '{h: hidx, c: COUNT_WIDTH'(req.start_count)};
					i_q      <= SL_W'(size_q);
				end
			end
			S_EV_ROOT: begin
				ev_q <= hrd;
				i_q  <= '0;
			end
			S_TS_WAIT: i_q <= sl_rd;
			S_LD_CUR: begin
				cur_q.h <= hrd.h;
				cur_q.c <= (mode_q == MODE_TOUCH) ? cnt_inc : hrd.c;
			end
			S_UP_CMP: begin
				if (cmp_le) begin
					i_q <= parent;
				end
			end
			S_DN_L: begin
				ch_q      <= hrd;
				ch_slot_q <= lc[SL_W-1:0];
			end
			S_DN_R: begin
				if (cmp_le) begin
					ch_q      <= hrd;
					ch_slot_q <= rc[SL_W-1:0];
				end
			end
			S_DN_CMP: begin
				if (!cmp_le) begin
					i_q <= ch_slot_q;
				end
			end
			default: begin
				mode_q <= mode_q;
			end
		endcase
		if (rsp_load) begin
			rsp_status_q <= status_q;
			rsp_ev_h_q   <= HANDLE_W'(ev_q.h);
			rsp_ev_c_q   <= FCOUNT_W'(ev_q.c);
			rsp_occ_q    <= OCC_W'(size_q);
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.evicted_handle = rsp_ev_h_q;
	assign rsp.evicted_count  = rsp_ev_c_q;
	assign rsp.occupancy      = rsp_occ_q;

`ifndef SYNTHESIS
	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(size_q) <= HEAP_DEPTH)
		else $error("heap size above depth");

	a_present_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_EV_ROOT |-> $countones(present_q) == int'(size_q))
		else $error("present flags disagree with heap size");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_DONE)
		else $error("response raised outside done state");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		acc && acc_go |=> !req.ready)
		else $error("request taken while heap work pending");
`endif

endmodule

// File: sv/lfu_ram.sv
module lfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
